### rtl/pidx_pkg.sv
// ----------------------------------------------------------------------------
// pidx_pkg
// Shared types and constants of the palette indexer: hash constant, slot
// tag width, default sizes and the controller state type.
// ----------------------------------------------------------------------------
package pidx_pkg;

	// packed rgba color
	localparam int COLOR_W = 32;

	// max_colors register
	localparam int CFG_W = 10;
	localparam logic [CFG_W-1:0] MAX_COLORS_RST = 10'd512;

	// default sizes
	localparam int PALETTE_DEPTH_DEF = 512;
	localparam int TABLE_SIZE_DEF = 1024;

	// image tag kept with every slot, tag zero never matches
	localparam int EPOCH_W = 8;

	// multiplier of the color hash
	localparam logic [COLOR_W-1:0] HASH_MULT = 32'h045d9f3b;

	// controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_READ,
		ST_CHECK
	} state_t;

endpackage

### rtl/palette_indexer_top.sv
// ----------------------------------------------------------------------------
// palette_indexer_top
// Path: a pixel passes the capture register, the hash register and the
// registered slot read to the result register; each extra probe adds a read.
// A new pixel is taken only as the last one finishes; a stalled result holds it.
// Reset: a sweep of TABLE_SIZE cycles clears the slot tags before the first
// pixel; a new image after every 255 images repeats that sweep.
// ----------------------------------------------------------------------------
module palette_indexer_top
	import pidx_pkg::*;
#(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
	parameter int TABLE_SIZE    = TABLE_SIZE_DEF,
	localparam int IDX_W = $clog2(PALETTE_DEPTH),
	localparam int CNT_W = $clog2(PALETTE_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	// pixel channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	input  logic [7:0]         alpha,
	input  logic               first_pixel,
	input  logic               last_pixel,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [IDX_W-1:0]   color_index,
	output logic               is_new,
	output logic [COLOR_W-1:0] palette_color,
	output logic [CNT_W-1:0]   color_count,
	output logic               overflow,
	output logic               image_done,
	// configuration channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_W-1:0]   max_colors
);

	localparam int ADDR_W = $clog2(TABLE_SIZE);
	localparam int PRB_W  = $clog2(TABLE_SIZE + 1);
	localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	state_t state_q, state_d;

	logic [CFG_W-1:0]   max_colors_q;
	logic [ADDR_W-1:0]  clr_q;
	logic               pend_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [CNT_W-1:0]   count_q;
	logic               ovf_q;
	logic [COLOR_W-1:0] color_q;
	logic               last_q;
	logic [PRB_W-1:0]   probes_q;
	logic [ADDR_W-1:0]  pos_q;
	logic               out_valid_q;

	logic [COLOR_W-1:0] hash;
	logic [EPOCH_W-1:0] rd_tag;
	logic [COLOR_W-1:0] rd_key;
	logic [IDX_W-1:0]   rd_index;

	logic               used, hit, full, last_probe, clr_end;
	logic               done, step, insert, ovf_set, finish, out_free;
	logic               in_fire, wrap;
	logic [IDX_W-1:0]   res_idx;
	logic               rd_en, wr_en;
	logic [ADDR_W-1:0]  rd_addr, wr_addr;
	logic [EPOCH_W-1:0] wr_tag;
	logic [COLOR_W-1:0] wr_key;
	logic [IDX_W-1:0]   wr_index;

	// hash of the captured color
	pidx_hash u_hash (
		.clk   (clk),
		.color (color_q),
		.hash  (hash)
	);

	// slot table
	pidx_table #(
		.PALETTE_DEPTH (PALETTE_DEPTH),
		.TABLE_SIZE    (TABLE_SIZE)
	) u_table (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_tag   (wr_tag),
		.wr_key   (wr_key),
		.wr_index (wr_index),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_tag   (rd_tag),
		.rd_key   (rd_key),
		.rd_index (rd_index)
	);

	// probe decision on the slot just read
	always_comb begin
		used       = (rd_tag == epoch_q);
		hit        = used && (rd_key == color_q);
		full       = (CMP_W'(count_q) >= CMP_W'(max_colors_q)) ||
		             (count_q >= CNT_W'(PALETTE_DEPTH));
		last_probe = (probes_q == PRB_W'(TABLE_SIZE - 1));
		done       = 1'b0;
		step       = 1'b0;
		insert     = 1'b0;
		ovf_set    = 1'b0;
		res_idx    = '0;
		if (ovf_q) begin
			done = 1'b1;
		end else if (hit) begin
			done    = 1'b1;
			res_idx = rd_index;
		end else if (!used) begin
			done = 1'b1;
			if (full) begin
				ovf_set = 1'b1;
			end else begin
				insert  = 1'b1;
				res_idx = count_q[IDX_W-1:0];
			end
		end else if (last_probe) begin
			done    = 1'b1;
			ovf_set = 1'b1;
		end else begin
			step = 1'b1;
		end
	end

	// handshake terms
	assign out_free = !out_valid_q || out_ready;
	assign finish   = (state_q == ST_CHECK) && done && out_free;
	assign in_ready = (state_q == ST_IDLE) || finish;
	assign in_fire  = in_valid && in_ready;
	assign wrap     = first_pixel && (epoch_q == '1);
	assign clr_end  = (clr_q == ADDR_W'(TABLE_SIZE - 1));
	assign cfg_ready = 1'b1;

	// table access
	always_comb begin
		rd_en    = (state_q == ST_READ) || ((state_q == ST_CHECK) && step);
		rd_addr  = (state_q == ST_READ) ? hash[ADDR_W-1:0] : pos_q + 1'b1;
		wr_en    = (state_q == ST_CLEAR) || (finish && insert);
		wr_addr  = (state_q == ST_CLEAR) ? clr_q : pos_q;
		wr_tag   = (state_q == ST_CLEAR) ? '0 : epoch_q;
		wr_key   = color_q;
		wr_index = count_q[IDX_W-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_end) begin
					state_d = pend_q ? ST_READ : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_fire) begin
					state_d = wrap ? ST_CLEAR : ST_HASH;
				end
			end
			ST_HASH: begin
				state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (finish) begin
					if (in_fire) begin
						state_d = wrap ? ST_CLEAR : ST_HASH;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_colors_q <= MAX_COLORS_RST;
		end else if (cfg_valid) begin
			max_colors_q <= max_colors;
		end
	end

	// clearing sweep and image tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			pend_q  <= 1'b0;
			epoch_q <= EPOCH_W'(1);
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
				if (clr_end) begin
					pend_q  <= 1'b0;
					epoch_q <= EPOCH_W'(1);
				end
			end
			if (in_fire && first_pixel) begin
				if (wrap) begin
					pend_q <= 1'b1;
				end else begin
					epoch_q <= epoch_q + 1'b1;
				end
			end
		end
	end

	// palette count and sticky overflow, a new image starts empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (in_fire && first_pixel) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (finish && insert) begin
				count_q <= count_q + 1'b1;
			end
			if (finish && ovf_set) begin
				ovf_q <= 1'b1;
			end
		end
	end

	// pixel capture and probe position
	always_ff @(posedge clk) begin
		if (in_fire) begin
			color_q  <= {red, green, blue, alpha};
			last_q   <= last_pixel;
			probes_q <= '0;
		end
		if (state_q == ST_READ) begin
			pos_q <= hash[ADDR_W-1:0];
		end
		if ((state_q == ST_CHECK) && step) begin
			pos_q    <= pos_q + 1'b1;
			probes_q <= probes_q + 1'b1;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (finish) begin
			color_index   <= res_idx;
			is_new        <= insert;
			palette_color <= color_q;
			color_count   <= insert ? count_q + 1'b1 : count_q;
			overflow      <= ovf_q || ovf_set;
			image_done    <= last_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/pidx_hash.sv
// ----------------------------------------------------------------------------
// pidx_hash
// Shift-xor, multiply and shift-xor hash of a packed color. The product is
// registered; the final fold is taken from the register.
// ----------------------------------------------------------------------------
module pidx_hash
	import pidx_pkg::*;
(
	input  logic               clk,
	input  logic [COLOR_W-1:0] color,
	output logic [COLOR_W-1:0] hash
);

	logic [COLOR_W-1:0] mix;
	logic [COLOR_W-1:0] prod_s1;

	// first fold
	assign mix = color ^ (color >> 16);

	// multiply, low word kept
	always_ff @(posedge clk) begin
		prod_s1 <= mix * HASH_MULT;
	end

	// second fold
	assign hash = prod_s1 ^ (prod_s1 >> 16);

endmodule

### rtl/pidx_table.sv
// ----------------------------------------------------------------------------
// pidx_table
// Open-addressed slot table: one entry holds the image tag, the color key
// and the palette index. One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pidx_table
	import pidx_pkg::*;
#(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
	parameter int TABLE_SIZE    = TABLE_SIZE_DEF,
	localparam int IDX_W  = $clog2(PALETTE_DEPTH),
	localparam int ADDR_W = $clog2(TABLE_SIZE)
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  logic [EPOCH_W-1:0] wr_tag,
	input  logic [COLOR_W-1:0] wr_key,
	input  logic [IDX_W-1:0]   wr_index,
	input  logic               rd_en,
	input  logic [ADDR_W-1:0]  rd_addr,
	output logic [EPOCH_W-1:0] rd_tag,
	output logic [COLOR_W-1:0] rd_key,
	output logic [IDX_W-1:0]   rd_index
);

	localparam int ENT_W = EPOCH_W + COLOR_W + IDX_W;

	logic [ENT_W-1:0] mem [TABLE_SIZE];
	logic [ENT_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_tag, wr_key, wr_index};
		end
	end

	// read port, data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_tag   = rd_data_q[ENT_W-1 -: EPOCH_W];
	assign rd_key   = rd_data_q[IDX_W +: COLOR_W];
	assign rd_index = rd_data_q[IDX_W-1:0];

endmodule
